// ===== rtl/gffrc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid flood fill package
// Shared constants and command codes for the grid flood fill block.
// ----------------------------------------------------------------------------
package gffrc_pkg;
    localparam int GRID_COLS_DEF   = 64;
    localparam int GRID_ROWS_DEF   = 64;
    localparam int STACK_DEPTH_DEF = 4096;
    localparam int COUNT_W         = 13;
    localparam int COORD_W         = 6;
    localparam int COLOR_W         = 2;

    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_FILL  = 2'd2;

    localparam logic [1:0] REG_P0_COL = 2'd0;
    localparam logic [1:0] REG_P0_ROW = 2'd1;
    localparam logic [1:0] REG_P1_COL = 2'd2;
    localparam logic [1:0] REG_P1_ROW = 2'd3;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
endpackage : gffrc_pkg

// ===== rtl/gffrc_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module gffrc_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule : gffrc_ram
`default_nettype wire

// ===== rtl/grid_flood_fill_region_count.sv =====
`timescale 1ns / 1ps
`default_nettype none
// A write passes through S_RDDONE and S_OUT after it is accepted, and a read through
// S_RDWAIT, S_RDDONE and S_OUT; a fill sweeps the visited marks clear before each walk,
// then visits the cells of the region from the stack, and a repainting fill walks twice.
// Throughput: one item at a time; the next item is taken only once the result
// has been accepted, and the single read port of each memory sets the pace.
// Reset: control clears and the player start cells reset to (0,0) and (63,63) at
// once; grid holds garbage until written, visited marks are swept before each walk.
// ----------------------------------------------------------------------------
// Grid flood fill region count
// Stack-based 4-connected fill over a grid memory, sequenced one step a cycle.
// ----------------------------------------------------------------------------
module grid_flood_fill_region_count #(
    parameter int GRID_COLS   = gffrc_pkg::GRID_COLS_DEF,
    parameter int GRID_ROWS   = gffrc_pkg::GRID_ROWS_DEF,
    parameter int STACK_DEPTH = gffrc_pkg::STACK_DEPTH_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // command[1:0], col[7:2], row[13:8], color[15:14]
    input  wire logic [15:0] s_axis_tdata,
    // player
    input  wire logic        s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // cell_color[1:0], region_count[14:2], zero pad [15]
    output logic      [15:0] m_axis_tdata,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [5:0]  cfg_data
);
    localparam int CELLS = GRID_COLS * GRID_ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
    localparam int RW    = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
    localparam int SW    = $clog2(STACK_DEPTH);
    localparam int TW    = SW + 1;
    // Stack entries hold the row above the column, so no address split is needed.
    localparam int IW    = CW + RW;
    localparam int COUNT_W_L = gffrc_pkg::COUNT_W;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_RDWAIT = 4'd1;
    localparam logic [3:0] S_RDDONE = 4'd2;
    localparam logic [3:0] S_START  = 4'd3;
    localparam logic [3:0] S_CLEAR  = 4'd4;
    localparam logic [3:0] S_SEED   = 4'd5;
    localparam logic [3:0] S_POP    = 4'd6;
    localparam logic [3:0] S_POPW   = 4'd7;
    localparam logic [3:0] S_NBR    = 4'd8;
    localparam logic [3:0] S_NBRW   = 4'd9;
    localparam logic [3:0] S_NBRCHK = 4'd10;
    localparam logic [3:0] S_WALKEND= 4'd11;
    localparam logic [3:0] S_OUT    = 4'd12;
    localparam logic [3:0] S_SEEDW  = 4'd13;

    logic [3:0] state_reg, state_next;
    logic [5:0] p0c_reg, p0r_reg, p1c_reg, p1r_reg;
    logic [1:0] cmd_reg, color_reg, match_reg;
    logic       paint_reg;
    logic [CW-1:0] cur_c_reg, cur_c_next;
    logic [RW-1:0] cur_r_reg, cur_r_next;
    logic [CW-1:0] sc_reg;
    logic [RW-1:0] sr_reg;
    logic [CW-1:0] nc_reg;
    logic [RW-1:0] nr_reg;
    logic       nok_reg;
    logic [1:0] nbr_reg;
    logic [AW:0]  clr_reg;
    logic [TW-1:0] top_reg;
    logic [COUNT_W_L-1:0] cnt_reg;
    logic [1:0] rd_reg;
    logic [15:0] out_reg;
    logic       outv_reg;

    // grid memory
    logic          g_we;
    logic [AW-1:0] g_waddr, g_raddr;
    logic [1:0]    g_wdata, g_rdata;
    // visited memory
    logic          v_we;
    logic [AW-1:0] v_waddr, v_raddr;
    logic          v_wdata, v_rdata;
    // stack memory
    logic          k_we;
    logic [SW-1:0] k_waddr, k_raddr;
    logic [IW-1:0] k_wdata, k_rdata;

    gffrc_ram #(.WIDTH(2), .DEPTH(CELLS)) u_grid (
        .clk(clk), .we(g_we), .waddr(g_waddr), .wdata(g_wdata),
        .raddr(g_raddr), .rdata(g_rdata));
    gffrc_ram #(.WIDTH(1), .DEPTH(CELLS)) u_vis (
        .clk(clk), .we(v_we), .waddr(v_waddr), .wdata(v_wdata),
        .raddr(v_raddr), .rdata(v_rdata));
    gffrc_ram #(.WIDTH(IW), .DEPTH(STACK_DEPTH)) u_stack (
        .clk(clk), .we(k_we), .waddr(k_waddr), .wdata(k_wdata),
        .raddr(k_raddr), .rdata(k_rdata));

    function automatic logic [AW-1:0] addr_of(input logic [CW-1:0] c,
                                               input logic [RW-1:0] r);
        logic [AW+CW+RW:0] a;
        a = (AW+CW+RW+1)'(r) * (AW+CW+RW+1)'(GRID_COLS) + (AW+CW+RW+1)'(c);
        return a[AW-1:0];
    endfunction

    wire logic [1:0] in_cmd   = s_axis_tdata[1:0];
    wire logic [5:0] in_col   = s_axis_tdata[7:2];
    wire logic [5:0] in_row   = s_axis_tdata[13:8];
    wire logic [1:0] in_color = s_axis_tdata[15:14];
    wire logic       in_on    = (32'(in_col) < GRID_COLS) && (32'(in_row) < GRID_ROWS);
    wire logic [5:0] st_c     = s_axis_tuser ? p1c_reg : p0c_reg;
    wire logic [5:0] st_r     = s_axis_tuser ? p1r_reg : p0r_reg;
    wire logic       st_on    = (32'(st_c) < GRID_COLS) && (32'(st_r) < GRID_ROWS);
    wire logic       accept   = s_axis_tvalid && s_axis_tready;
    wire logic       stk_full = (32'(top_reg) >= STACK_DEPTH);

    assign s_axis_tready = (state_reg == S_IDLE) && !outv_reg;
    assign m_axis_tvalid = outv_reg;
    assign m_axis_tdata  = out_reg;

    // neighbour candidate for the current cell
    logic [CW-1:0] cand_c;
    logic [RW-1:0] cand_r;
    logic          cand_ok;
    always_comb
    begin
        cand_c  = cur_c_reg;
        cand_r  = cur_r_reg;
        cand_ok = 1'b0;
        case (nbr_reg)
            2'd0:
            begin
                cand_c  = cur_c_reg - 1'b1;
                cand_ok = (cur_c_reg != '0);
            end
            2'd1:
            begin
                cand_c  = cur_c_reg + 1'b1;
                cand_ok = (32'(cur_c_reg) + 1 < GRID_COLS);
            end
            2'd2:
            begin
                cand_r  = cur_r_reg - 1'b1;
                cand_ok = (cur_r_reg != '0);
            end
            default:
            begin
                cand_r  = cur_r_reg + 1'b1;
                cand_ok = (32'(cur_r_reg) + 1 < GRID_ROWS);
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        cur_c_next = cur_c_reg;
        cur_r_next = cur_r_reg;
        g_we = 1'b0; g_waddr = addr_of(cur_c_reg, cur_r_reg); g_wdata = color_reg;
        g_raddr = addr_of(nc_reg, nr_reg);
        v_we = 1'b0; v_waddr = addr_of(nc_reg, nr_reg); v_wdata = 1'b1;
        v_raddr = addr_of(nc_reg, nr_reg);
        k_we = 1'b0; k_waddr = top_reg[SW-1:0];
        k_wdata = {nr_reg, nc_reg};
        k_raddr = top_reg[SW-1:0] - 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    g_raddr = addr_of(CW'(in_col), RW'(in_row));
                    if (in_cmd == gffrc_pkg::CMD_WRITE)
                    begin
                        g_we = in_on;
                        g_waddr = addr_of(CW'(in_col), RW'(in_row));
                        g_wdata = in_color;
                        state_next = S_RDDONE;
                    end
                    else if (in_cmd == gffrc_pkg::CMD_READ)
                        state_next = S_RDWAIT;
                    else if (in_cmd == gffrc_pkg::CMD_FILL && st_on)
                    begin
                        g_raddr = addr_of(CW'(st_c), RW'(st_r));
                        state_next = S_START;
                    end
                    else
                        state_next = S_RDDONE;
                end
            end
            S_RDWAIT: state_next = S_RDDONE;
            S_RDDONE: state_next = S_OUT;
            S_START:  state_next = S_CLEAR;
            S_CLEAR:
            begin
                v_we = 1'b1;
                v_waddr = clr_reg[AW-1:0];
                v_wdata = 1'b0;
                if (32'(clr_reg) == CELLS - 1)
                    state_next = S_SEED;
            end
            S_SEED:
            begin
                // read seed cell colour and visited mark
                state_next = S_SEEDW;
            end
            S_SEEDW: state_next = S_NBRCHK;
            S_POP:
            begin
                if (top_reg == '0)
                    state_next = S_WALKEND;
                else
                    state_next = S_POPW;
            end
            S_POPW:
            begin
                cur_c_next = k_rdata[CW-1:0];
                cur_r_next = k_rdata[IW-1:CW];
                state_next = S_NBR;
            end
            S_NBR:
            begin
                g_we = paint_reg;
                state_next = S_NBRW;
            end
            S_NBRW: state_next = S_NBRCHK;
            S_NBRCHK:
            begin
                if (nok_reg && !v_rdata && g_rdata == match_reg && !stk_full)
                begin
                    v_we = 1'b1;
                    k_we = 1'b1;
                end
                if (nbr_reg == 2'd3)
                    state_next = S_POP;
                else
                    state_next = S_NBR;
            end
            S_WALKEND:
            begin
                if (paint_reg)
                    state_next = S_CLEAR;
                else
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            p0c_reg <= 6'd0; p0r_reg <= 6'd0;
            p1c_reg <= 6'd63; p1r_reg <= 6'd63;
            outv_reg <= 1'b0;
            top_reg <= '0;
            nbr_reg <= '0;
            clr_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cur_c_reg <= cur_c_next;
            cur_r_reg <= cur_r_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    gffrc_pkg::REG_P0_COL: p0c_reg <= cfg_data;
                    gffrc_pkg::REG_P0_ROW: p0r_reg <= cfg_data;
                    gffrc_pkg::REG_P1_COL: p1c_reg <= cfg_data;
                    default:               p1r_reg <= cfg_data;
                endcase
            end
            if (outv_reg && m_axis_tready)
                outv_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        cmd_reg   <= in_cmd;
                        color_reg <= in_color;
                        sc_reg    <= CW'(st_c);
                        sr_reg    <= RW'(st_r);
                        cnt_reg   <= '0;
                        rd_reg    <= 2'd0;
                        if (in_cmd == gffrc_pkg::CMD_READ && !in_on)
                            cmd_reg <= gffrc_pkg::CMD_WRITE;
                    end
                end
                S_RDWAIT:
                begin
                    rd_reg <= g_rdata;
                end
                S_START:
                begin
                    match_reg <= g_rdata;
                    paint_reg <= (g_rdata != color_reg);
                    if (g_rdata == color_reg)
                        match_reg <= color_reg;
                    clr_reg   <= '0;
                end
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (state_next == S_SEED)
                    begin
                        nc_reg  <= sc_reg;
                        nr_reg  <= sr_reg;
                        nok_reg <= 1'b1;
                        nbr_reg <= 2'd3;
                        top_reg <= '0;
                        cnt_reg <= '0;
                    end
                end
                S_NBR:
                begin
                    nc_reg  <= cand_c;
                    nr_reg  <= cand_r;
                    nok_reg <= cand_ok;
                end
                S_NBRCHK:
                begin
                    if (v_we)
                        top_reg <= top_reg + 1'b1;
                    nbr_reg <= nbr_reg + 1'b1;
                end
                S_POP:
                begin
                    if (top_reg != '0)
                        top_reg <= top_reg - 1'b1;
                end
                S_POPW:
                begin
                    if (cnt_reg != gffrc_pkg::COUNT_MAX)
                        cnt_reg <= cnt_reg + 1'b1;
                end
                S_WALKEND:
                begin
                    // second walk counts the region of the new colour
                    paint_reg <= 1'b0;
                    match_reg <= color_reg;
                    clr_reg   <= '0;
                    if (!paint_reg)
                    begin
                        cnt_reg <= cnt_reg;
                    end
                end
                S_OUT:
                begin
                    outv_reg <= 1'b1;
                    out_reg  <= {1'b0,
                                 (cmd_reg == gffrc_pkg::CMD_FILL) ? cnt_reg
                                                                  : {COUNT_W_L{1'b0}},
                                 (cmd_reg == gffrc_pkg::CMD_READ) ? rd_reg : 2'd0};
                end
                default: ;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> (state_reg == S_IDLE && !outv_reg))
        else $error("ready outside idle");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (outv_reg && !m_axis_tready) |=> outv_reg)
        else $error("result dropped");
    a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(top_reg) <= STACK_DEPTH)
        else $error("stack overflow");
`endif
endmodule : grid_flood_fill_region_count
`default_nettype wire

// ===== dv/grid_flood_fill_region_count_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid flood fill checker
// Watches the command, result and register write channels. It keeps its own
// copy of the grid and the player start cells, and works out the colour or
// region size that each accepted command must give. Each result is then
// compared with the oldest outstanding expectation.
// ----------------------------------------------------------------------------
module grid_flood_fill_region_count_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,
    input  logic        s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [15:0] m_axis_tdata,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [5:0]  cfg_data,
    output int          mismatches,
    output int          outstanding
);
    localparam int COLS  = gffrc_pkg::GRID_COLS_DEF;
    localparam int ROWS  = gffrc_pkg::GRID_ROWS_DEF;
    localparam int CELLS = COLS * ROWS;

    typedef struct packed {
        logic                          pad;
        logic [gffrc_pkg::COUNT_W-1:0] region_count;
        logic [gffrc_pkg::COLOR_W-1:0] cell_color;
    } answer_t;

    logic [gffrc_pkg::COLOR_W-1:0] shadow_grid [CELLS];
    bit                            seen [CELLS];
    int                            walk_stack [CELLS];
    logic [gffrc_pkg::COORD_W-1:0] start_col [2];
    logic [gffrc_pkg::COORD_W-1:0] start_row [2];
    answer_t                       answers_due [$];

    // Visits the 4-connected region of one colour from a start cell, painting
    // it on the way if asked, and gives its size.
    function automatic int region_walk(int sc, int sr, logic [1:0] match, bit paint,
                                       logic [1:0] newc);
        int depth;
        int total;
        int idx;
        int c;
        int r;
        int nc;
        int nr;
        int k;
        for (int i = 0; i < CELLS; i++)
            seen[i] = 1'b0;
        depth = 0;
        total = 0;
        idx = sr * COLS + sc;
        if (shadow_grid[idx] == match)
        begin
            seen[idx] = 1'b1;
            walk_stack[depth++] = idx;
        end
        while (depth > 0)
        begin
            idx = walk_stack[--depth];
            c = idx % COLS;
            r = idx / COLS;
            if (paint)
                shadow_grid[idx] = newc;
            total++;
            for (k = 0; k < 4; k++)
            begin
                nc = c + ((k == 0) ? -1 : (k == 1) ? 1 : 0);
                nr = r + ((k == 2) ? -1 : (k == 3) ? 1 : 0);
                if (nc >= 0 && nc < COLS && nr >= 0 && nr < ROWS)
                begin
                    idx = nr * COLS + nc;
                    if (!seen[idx] && shadow_grid[idx] == match)
                    begin
                        seen[idx] = 1'b1;
                        walk_stack[depth++] = idx;
                    end
                end
            end
        end
        return total;
    endfunction

    function automatic answer_t predict_answer(logic [15:0] cmd_item, logic who);
        answer_t                       ans;
        logic [1:0]                    cmd;
        logic [gffrc_pkg::COORD_W-1:0] c;
        logic [gffrc_pkg::COORD_W-1:0] r;
        logic [1:0]                    colour;
        logic [1:0]                    old;
        int                            sidx;
        int                            n;
        ans = '0;
        cmd = cmd_item[1:0];
        c = cmd_item[7:2];
        r = cmd_item[13:8];
        colour = cmd_item[15:14];
        if (cmd == gffrc_pkg::CMD_WRITE)
            shadow_grid[r * COLS + c] = colour;
        else if (cmd == gffrc_pkg::CMD_READ)
            ans.cell_color = shadow_grid[r * COLS + c];
        else if (cmd == gffrc_pkg::CMD_FILL)
        begin
            sidx = start_row[who] * COLS + start_col[who];
            old = shadow_grid[sidx];
            if (old != colour)
                void'(region_walk(start_col[who], start_row[who], old, 1'b1, colour));
            n = region_walk(start_col[who], start_row[who], colour, 1'b0, 2'd0);
            ans.region_count = (n > gffrc_pkg::COUNT_MAX) ? gffrc_pkg::COUNT_MAX
                                                          : n[gffrc_pkg::COUNT_W-1:0];
        end
        return ans;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        answer_t want;
        answer_t got;
        if (!rst_n)
        begin
            start_col[0] <= '0;
            start_row[0] <= '0;
            start_col[1] <= '1;
            start_row[1] <= '1;
            mismatches <= 0;
            outstanding <= 0;
            answers_due.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    gffrc_pkg::REG_P0_COL: start_col[0] <= cfg_data;
                    gffrc_pkg::REG_P0_ROW: start_row[0] <= cfg_data;
                    gffrc_pkg::REG_P1_COL: start_col[1] <= cfg_data;
                    gffrc_pkg::REG_P1_ROW: start_row[1] <= cfg_data;
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata;
                if (answers_due.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("%0t: result %h arrived with nothing outstanding",
                                 $realtime, got);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    want = answers_due.pop_front();
                    if (got.cell_color !== want.cell_color
                        || got.region_count !== want.region_count
                        || got.pad !== want.pad)
                    begin
                        if (mismatches < 10)
                            $display("%0t: colour %0d count %0d pad %b, expected %0d %0d %b",
                                     $realtime, got.cell_color, got.region_count, got.pad,
                                     want.cell_color, want.region_count, want.pad);
                        mismatches <= mismatches + 1;
                    end
                end
            end
            // Start cells are sampled before this edge's register write lands,
            // which matches the block only because writes happen while idle.
            if (s_axis_tvalid && s_axis_tready)
                answers_due.push_back(predict_answer(s_axis_tdata, s_axis_tuser));
            outstanding <= answers_due.size();
        end
    end
endmodule

// ===== dv/grid_flood_fill_region_count_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid flood fill testbench
// Loads the whole grid, then runs directed and random cell writes, reads,
// fills and unused commands under several player start settings, with random
// stalls on both channels. The checker beside the block scores every result.
// ----------------------------------------------------------------------------
module grid_flood_fill_region_count_test;
    localparam logic [1:0] CMD_NONE   = 2'd3;
    localparam int         STALL_PCT  = 6;
    localparam int         DOG_LIMIT  = 1000000;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [5:0]  cfg_data;
    int          mismatches;
    int          outstanding;
    bit          steady;
    int          dog;
    int          fills_sent;
    int          reads_sent;

    grid_flood_fill_region_count dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    grid_flood_fill_region_count_checker scoreboard (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .mismatches(mismatches), .outstanding(outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            m_axis_tready <= steady || ($urandom_range(0, 99) >= STALL_PCT);
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            dog <= 0;
        else if (dog >= DOG_LIMIT)
        begin
            $display("Timed out with %0d results outstanding", outstanding);
            $display("*** FAILED ***");
            $finish;
        end
        else
            dog <= dog + 1;
    end

    task automatic send_item(logic [1:0] cmd, logic [5:0] c, logic [5:0] r,
                             logic [1:0] colour, logic who);
        while (!steady && $urandom_range(0, 99) < STALL_PCT)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {colour, r, c, cmd};
        s_axis_tuser  <= who;
        if (cmd == gffrc_pkg::CMD_FILL)
            fills_sent++;
        if (cmd == gffrc_pkg::CMD_READ)
            reads_sent++;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // Holds the sender off until every result is back, then lets the block settle.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (20) @(posedge clk);
    endtask

    task automatic set_starts(logic [5:0] c0, logic [5:0] r0, logic [5:0] c1, logic [5:0] r1);
        drain();
        cfg_we <= 1'b1; cfg_index <= gffrc_pkg::REG_P0_COL; cfg_data <= c0; @(posedge clk);
        cfg_index <= gffrc_pkg::REG_P0_ROW; cfg_data <= r0; @(posedge clk);
        cfg_index <= gffrc_pkg::REG_P1_COL; cfg_data <= c1; @(posedge clk);
        cfg_index <= gffrc_pkg::REG_P1_ROW; cfg_data <= r1; @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_item();
        int pick;
        logic [1:0] cmd;
        pick = $urandom_range(0, 99);
        cmd = (pick < 35) ? gffrc_pkg::CMD_WRITE : (pick < 65) ? gffrc_pkg::CMD_READ :
              (pick < 92) ? gffrc_pkg::CMD_FILL : CMD_NONE;
        send_item(cmd, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                  2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        cfg_we = 1'b0;
        cfg_index = gffrc_pkg::REG_P0_COL;
        cfg_data = '0;
        steady = 1'b0;
        dog = 0;
        fills_sent = 0;
        reads_sent = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Loads the grid, then fills on the reset start cells before any register write.
        for (int r = 0; r < 64; r++)
            for (int c = 0; c < 64; c++)
                send_item(gffrc_pkg::CMD_WRITE, 6'(c), 6'(r),
                          $urandom_range(0, 1) ? 2'd0 : 2'($urandom_range(0, 3)), 1'b0);
        send_item(gffrc_pkg::CMD_FILL, 6'd0, 6'd0, 2'd3, 1'b0);
        send_item(gffrc_pkg::CMD_FILL, 6'd0, 6'd0, 2'd3, 1'b1);
        send_item(gffrc_pkg::CMD_READ, 6'd63, 6'd63, 2'd0, 1'b0);
        set_starts(6'd0, 6'd0, 6'd63, 6'd63);

        // Directed: corner cells, every colour, unused command and same-colour fills.
        send_item(gffrc_pkg::CMD_WRITE, 6'd63, 6'd0, 2'd3, 1'b1);
        send_item(gffrc_pkg::CMD_WRITE, 6'd0, 6'd63, 2'd0, 1'b0);
        send_item(gffrc_pkg::CMD_READ, 6'd63, 6'd0, 2'd0, 1'b0);
        send_item(gffrc_pkg::CMD_READ, 6'd0, 6'd63, 2'd3, 1'b1);
        send_item(gffrc_pkg::CMD_READ, 6'd0, 6'd0, 2'd0, 1'b0);
        send_item(CMD_NONE, 6'd63, 6'd63, 2'd3, 1'b1);
        send_item(CMD_NONE, 6'd0, 6'd0, 2'd0, 1'b0);
        send_item(gffrc_pkg::CMD_FILL, 6'd0, 6'd0, 2'd1, 1'b0);
        send_item(gffrc_pkg::CMD_FILL, 6'd0, 6'd0, 2'd1, 1'b0);
        send_item(gffrc_pkg::CMD_FILL, 6'd0, 6'd0, 2'd2, 1'b1);
        send_item(gffrc_pkg::CMD_FILL, 6'd0, 6'd0, 2'd0, 1'b1);
        send_item(gffrc_pkg::CMD_FILL, 6'd0, 6'd0, 2'd0, 1'b1);
        send_item(gffrc_pkg::CMD_READ, 6'd63, 6'd63, 2'd0, 1'b0);
        send_item(gffrc_pkg::CMD_READ, 6'd1, 6'd1, 2'd0, 1'b0);

        set_starts(6'd63, 6'd0, 6'd0, 6'd63);
        send_item(gffrc_pkg::CMD_FILL, 6'd0, 6'd0, 2'd3, 1'b0);
        send_item(gffrc_pkg::CMD_FILL, 6'd0, 6'd0, 2'd3, 1'b1);
        send_item(gffrc_pkg::CMD_FILL, 6'd0, 6'd0, 2'd2, 1'b0);

        set_starts(6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                   6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
        for (int i = 0; i < 40; i++)
        begin
            steady = (i >= 15 && i < 30);
            random_item();
        end
        steady = 1'b0;

        set_starts(6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                   6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
        for (int i = 0; i < 40; i++)
            random_item();

        drain();
        $display("Whole grid loaded, then %0d fills and %0d reads over four start settings.",
                 fills_sent, reads_sent);
        if (mismatches == 0 && outstanding == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/gffrc_pkg.sv
rtl/gffrc_ram.sv
rtl/grid_flood_fill_region_count.sv
dv/grid_flood_fill_region_count_checker.sv
dv/grid_flood_fill_region_count_test.sv
